// ===== hw/rtl/ppt_pkg.sv =====
package ppt_pkg;

  // Field widths
  localparam int unsigned XW    = 32;   // Q16.16 point coordinate
  localparam int unsigned PW    = 48;   // Q16.32 model parameter
  localparam int unsigned NPAR  = 8;

  // Datapath widths
  localparam int unsigned KW    = PW + 1;          // coefficient, 1 + p
  localparam int unsigned SPLIT = 24;              // coefficient split for partial products
  localparam int unsigned PPW   = (KW - SPLIT) + XW; // partial product
  localparam int unsigned PRW   = KW + XW;         // full product
  localparam int unsigned ACCW  = PRW + 3;         // sum at scale 2^48
  localparam int unsigned CW    = 36;              // CORDIC x / y
  localparam int unsigned ZW    = 34;              // CORDIC residual angle
  localparam int unsigned CORDIC_N = 32;

  // Divider widths
  localparam int unsigned DIV_PRESHIFT = 17;
  localparam int unsigned NW    = ACCW + DIV_PRESHIFT;
  localparam int unsigned DW    = ACCW;
  localparam int unsigned QW    = XW + 1;
  localparam int unsigned DIV_STAGES = QW + 1;

  // Turn conversion
  localparam int unsigned TURN_MW = 54;
  localparam logic [29:0] RAD2TURN    = 30'd683565276;
  localparam logic [31:0] CORDIC_GAIN = 32'd2608131496;

  // Fixed-point constants
  localparam logic signed [KW-1:0]   ONE_K    = KW'(33'h1_0000_0000);
  localparam logic signed [ACCW-1:0] D_ONE    = ACCW'(49'h1_0000_0000_0000);
  localparam logic signed [ACCW-1:0] RND_HALF = ACCW'(32'h8000_0000);
  localparam logic [XW-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [XW-1:0] SAT_NEG = 32'h8000_0000;

  // Mode codes
  localparam logic [2:0] MODE_TRANS = 3'd0;
  localparam logic [2:0] MODE_ROT   = 3'd1;
  localparam logic [2:0] MODE_SIM   = 3'd2;
  localparam logic [2:0] MODE_AFF   = 3'd3;
  localparam logic [2:0] MODE_HOMO  = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SAT   = 2'd1;
  localparam logic [1:0] ST_DZERO = 2'd2;

  typedef struct packed {
    logic [2:0]                 mode;
    logic signed [XW-1:0]       x;
    logic signed [XW-1:0]       y;
    logic [NPAR-1:0][PW-1:0]    p;
  } pt_item_t;

  typedef struct packed {
    logic          homo;
    logic [XW-1:0] lin_x;
    logic [XW-1:0] lin_y;
    logic          lin_sat;
    logic          dzero;
    logic [1:0]    nneg;
    logic [1:0]    qneg;
  } side_t;

  // Arctangent of 2^-i in binary angle units (2^32 per turn)
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'h2000_0000;
      5'd1:  a = 32'h12E4_051E;
      5'd2:  a = 32'h09FB_385B;
      5'd3:  a = 32'h0511_11D4;
      5'd4:  a = 32'h028B_0D43;
      5'd5:  a = 32'h0145_D7E1;
      5'd6:  a = 32'h00A2_F61E;
      5'd7:  a = 32'h0051_7C55;
      5'd8:  a = 32'h0028_BE53;
      5'd9:  a = 32'h0014_5F2F;
      5'd10: a = 32'h000A_2F98;
      5'd11: a = 32'h0005_17CC;
      5'd12: a = 32'h0002_8BE6;
      5'd13: a = 32'h0001_45F3;
      5'd14: a = 32'h0000_A2FA;
      5'd15: a = 32'h0000_517D;
      5'd16: a = 32'h0000_28BE;
      5'd17: a = 32'h0000_145F;
      5'd18: a = 32'h0000_0A30;
      5'd19: a = 32'h0000_0518;
      5'd20: a = 32'h0000_028C;
      5'd21: a = 32'h0000_0146;
      5'd22: a = 32'h0000_00A3;
      5'd23: a = 32'h0000_0051;
      5'd24: a = 32'h0000_0029;
      5'd25: a = 32'h0000_0014;
      5'd26: a = 32'h0000_000A;
      5'd27: a = 32'h0000_0005;
      5'd28: a = 32'h0000_0003;
      5'd29: a = 32'h0000_0001;
      5'd30: a = 32'h0000_0001;
      default: a = 32'h0000_0000;
    endcase
    return a;
  endfunction

endpackage

// ===== hw/rtl/ppt_div.sv =====
module ppt_div (
  input  logic                     clk,
  input  logic                     en,
  input  logic [ppt_pkg::NW-1:0]   num_i,
  input  logic [ppt_pkg::DW-1:0]   den_i,
  output logic [ppt_pkg::QW-1:0]   quo_o,
  output logic                     ovf_o
);

  localparam int unsigned CMPW = ppt_pkg::DW + ppt_pkg::QW;

  logic [ppt_pkg::NW-1:0] rem_r   [ppt_pkg::QW+1];
  logic [ppt_pkg::NW-1:0] rem_nxt [ppt_pkg::QW+1];
  logic [ppt_pkg::DW-1:0] den_r   [ppt_pkg::QW+1];
  logic [ppt_pkg::DW-1:0] den_nxt [ppt_pkg::QW+1];
  logic [ppt_pkg::QW-1:0] quo_r   [ppt_pkg::QW+1];
  logic [ppt_pkg::QW-1:0] quo_nxt [ppt_pkg::QW+1];
  logic [ppt_pkg::QW:0]   ovf_r;
  logic [ppt_pkg::QW:0]   ovf_nxt;
  logic [CMPW-1:0]        trial   [ppt_pkg::QW+1];

  // Overflow check, then one restoring quotient bit per stage, MSB first
  always_comb begin
    rem_nxt[0] = num_i;
    den_nxt[0] = den_i;
    quo_nxt[0] = '0;
    ovf_nxt[0] = CMPW'(num_i) >= (CMPW'(den_i) << ppt_pkg::QW);
    trial[0]   = '0;
    for (int s = 1; s <= ppt_pkg::QW; s++) begin
      trial[s]   = CMPW'(den_r[s-1]) << (ppt_pkg::QW - s);
      den_nxt[s] = den_r[s-1];
      ovf_nxt[s] = ovf_r[s-1];
      if (CMPW'(rem_r[s-1]) >= trial[s]) begin
        rem_nxt[s] = ppt_pkg::NW'(CMPW'(rem_r[s-1]) - trial[s]);
        quo_nxt[s] = quo_r[s-1] | (ppt_pkg::QW'(1) << (ppt_pkg::QW - s));
      end else begin
        rem_nxt[s] = rem_r[s-1];
        quo_nxt[s] = quo_r[s-1];
      end
    end
  end

  // Advance all stages together
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      den_r <= den_nxt;
      quo_r <= quo_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign quo_o = quo_r[ppt_pkg::QW];
  assign ovf_o = ovf_r[ppt_pkg::QW];

endmodule

// ===== hw/rtl/parametric_point_transform.sv =====
// Throughput: one transaction per cycle; the pipeline moves as a whole and
// holds while a result waits under out_stall.
// Depth is set by the 32-stage CORDIC and the 34-stage quotient pipeline.
// Reset (synchronous, active low) clears all valid bits; data is not reset.
module parametric_point_transform (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_mode,
  input  logic signed [31:0] in_x_in,
  input  logic signed [31:0] in_y_in,
  input  logic signed [47:0] in_param_0,
  input  logic signed [47:0] in_param_1,
  input  logic signed [47:0] in_param_2,
  input  logic signed [47:0] in_param_3,
  input  logic signed [47:0] in_param_4,
  input  logic signed [47:0] in_param_5,
  input  logic signed [47:0] in_param_6,
  input  logic signed [47:0] in_param_7,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x_out,
  output logic signed [31:0] out_y_out,
  output logic [1:0]         out_status
);

  localparam int unsigned NC = ppt_pkg::CORDIC_N;
  localparam int unsigned ND = ppt_pkg::DIV_STAGES;

  logic adv;

  // Output register
  logic                    out_valid_r;
  logic [ppt_pkg::XW-1:0]  out_x_r, out_x_nxt;
  logic [ppt_pkg::XW-1:0]  out_y_r, out_y_nxt;
  logic [1:0]              out_status_r, out_status_nxt;

  // Turn conversion stages
  ppt_pkg::pt_item_t                   in_item;
  logic [ppt_pkg::TURN_MW-1:0]         plo_c;
  logic signed [ppt_pkg::TURN_MW-1:0]  phi_a, phi_b, phi_c;
  logic                                t1_v_r;
  ppt_pkg::pt_item_t                   t1_item_r;
  logic [ppt_pkg::TURN_MW-1:0]         t1_plo_r;
  logic signed [ppt_pkg::TURN_MW-1:0]  t1_phi_r;
  logic [63:0]                         turn_sum;
  logic [31:0]                         turn, turn_f;
  logic                                flip_c;
  logic                                t2_v_r;
  ppt_pkg::pt_item_t                   t2_item_r;
  logic signed [ppt_pkg::ZW-1:0]       t2_z_r;
  logic                                t2_flip_r;

  // CORDIC stages
  logic signed [ppt_pkg::CW-1:0] cx_in [NC], cy_in [NC], cx_nxt [NC], cy_nxt [NC];
  logic signed [ppt_pkg::CW-1:0] cx_r [NC], cy_r [NC];
  logic signed [ppt_pkg::ZW-1:0] cz_in [NC], cz_nxt [NC], cz_r [NC];
  logic signed [ppt_pkg::ZW-1:0] atan_z [NC];
  logic [NC-1:0]                 cflip_in, cflip_r, cv_in, cv_r;
  ppt_pkg::pt_item_t             citem_in [NC], citem_r [NC];

  // Multiply and sum stages
  ppt_pkg::pt_item_t               mi;
  logic signed [ppt_pkg::CW-1:0]   rc, rs, rs_neg;
  logic signed [ppt_pkg::KW-1:0]   k [6];
  logic signed [ppt_pkg::KW-1:0]   pk [ppt_pkg::NPAR];
  logic signed [ppt_pkg::PW-1:0]   c0_c, c1_c;
  logic signed [ppt_pkg::PPW-1:0]  m1_lo_nxt [6], m1_hi_nxt [6];
  logic signed [ppt_pkg::PPW-1:0]  m1_lo_r [6], m1_hi_r [6];
  logic                            m1_v_r, m1_homo_r;
  logic signed [ppt_pkg::PW-1:0]   m1_c0_r, m1_c1_r;
  logic signed [ppt_pkg::PRW-1:0]  m2_prod_nxt [6], m2_prod_r [6];
  logic                            m2_v_r, m2_homo_r;
  logic signed [ppt_pkg::PW-1:0]   m2_c0_r, m2_c1_r;
  logic signed [ppt_pkg::ACCW-1:0] m3_acc_nxt [3], m3_acc_r [3];
  logic                            m3_v_r, m3_homo_r;

  // Rounding and divide setup
  logic signed [ppt_pkg::ACCW-1:0] lin_rnd [2];
  logic [ppt_pkg::XW-1:0]          lin_val [2];
  logic [1:0]                      lin_sat;
  logic [ppt_pkg::ACCW-1:0]        an [2];
  logic [ppt_pkg::ACCW-1:0]        ad;
  logic [ppt_pkg::NW-1:0]          num_c [2];
  ppt_pkg::side_t                  side_c;
  logic                            h1_v_r;
  logic [ppt_pkg::NW-1:0]          h1_num_r [2];
  logic [ppt_pkg::DW-1:0]          h1_den_r;
  ppt_pkg::side_t                  h1_side_r;

  // Divider and side pipeline
  logic [ppt_pkg::QW-1:0] quo [2];
  logic [1:0]             ovf;
  logic [ND-1:0]          sv_r;
  ppt_pkg::side_t         sd_r [ND];
  ppt_pkg::side_t         sd;
  logic [ppt_pkg::XW-1:0] hq_val [2];
  logic [1:0]             hq_sat;

  // Global advance: the whole pipeline holds only while a result waits
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // Turn conversion: p2 * RAD2TURN split into two partial products
  always_comb begin
    in_item.mode = in_mode;
    in_item.x    = in_x_in;
    in_item.y    = in_y_in;
    in_item.p[0] = in_param_0;
    in_item.p[1] = in_param_1;
    in_item.p[2] = in_param_2;
    in_item.p[3] = in_param_3;
    in_item.p[4] = in_param_4;
    in_item.p[5] = in_param_5;
    in_item.p[6] = in_param_6;
    in_item.p[7] = in_param_7;
    plo_c = ppt_pkg::TURN_MW'(in_param_2[23:0]) * ppt_pkg::TURN_MW'(ppt_pkg::RAD2TURN);
    phi_a = ppt_pkg::TURN_MW'($signed(in_param_2[47:24]));
    phi_b = $signed(ppt_pkg::TURN_MW'(ppt_pkg::RAD2TURN));
    phi_c = phi_a * phi_b;
  end

  // Round to binary angle and fold the half turn around 180 degrees
  always_comb begin
    turn_sum = (64'(t1_phi_r) << 24) + 64'(t1_plo_r) + 64'h0000_0000_8000_0000;
    turn     = turn_sum[63:32];
    flip_c   = turn[31] ^ turn[30];
    turn_f   = {turn[31] ^ flip_c, turn[30:0]};
  end

  // CORDIC rotation, one iteration per stage
  always_comb begin
    cx_in[0]    = ppt_pkg::CW'($signed({1'b0, ppt_pkg::CORDIC_GAIN}));
    cy_in[0]    = '0;
    cz_in[0]    = t2_z_r;
    cflip_in[0] = t2_flip_r;
    cv_in[0]    = t2_v_r;
    citem_in[0] = t2_item_r;
    for (int i = 1; i < NC; i++) begin
      cx_in[i]    = cx_r[i-1];
      cy_in[i]    = cy_r[i-1];
      cz_in[i]    = cz_r[i-1];
      cflip_in[i] = cflip_r[i-1];
      cv_in[i]    = cv_r[i-1];
      citem_in[i] = citem_r[i-1];
    end
    for (int i = 0; i < NC; i++) begin
      atan_z[i] = $signed(ppt_pkg::ZW'(ppt_pkg::atan_turn(5'(i))));
      if (!cz_in[i][ppt_pkg::ZW-1]) begin
        cx_nxt[i] = cx_in[i] - (cy_in[i] >>> i);
        cy_nxt[i] = cy_in[i] + (cx_in[i] >>> i);
        cz_nxt[i] = cz_in[i] - atan_z[i];
      end else begin
        cx_nxt[i] = cx_in[i] + (cy_in[i] >>> i);
        cy_nxt[i] = cy_in[i] - (cx_in[i] >>> i);
        cz_nxt[i] = cz_in[i] + atan_z[i];
      end
    end
  end

  // Coefficient select and partial products
  always_comb begin
    mi     = citem_r[NC-1];
    rc     = cflip_r[NC-1] ? -cx_r[NC-1] : cx_r[NC-1];
    rs     = cflip_r[NC-1] ? -cy_r[NC-1] : cy_r[NC-1];
    rs_neg = -rs;
    for (int i = 0; i < ppt_pkg::NPAR; i++) begin
      pk[i] = ppt_pkg::KW'($signed(mi.p[i]));
    end
    for (int j = 0; j < 6; j++) begin
      k[j] = '0;
    end
    c0_c = $signed(mi.p[0]);
    c1_c = $signed(mi.p[1]);
    case (mi.mode)
      ppt_pkg::MODE_ROT: begin
        k[0] = ppt_pkg::KW'(rc);
        k[1] = ppt_pkg::KW'(rs_neg);
        k[2] = ppt_pkg::KW'(rs);
        k[3] = ppt_pkg::KW'(rc);
      end
      ppt_pkg::MODE_SIM: begin
        k[0] = ppt_pkg::ONE_K + pk[2];
        k[1] = -pk[3];
        k[2] = pk[3];
        k[3] = ppt_pkg::ONE_K + pk[2];
      end
      ppt_pkg::MODE_AFF: begin
        k[0] = ppt_pkg::ONE_K + pk[2];
        k[1] = pk[3];
        k[2] = pk[4];
        k[3] = ppt_pkg::ONE_K + pk[5];
      end
      ppt_pkg::MODE_HOMO: begin
        k[0] = ppt_pkg::ONE_K + pk[0];
        k[1] = pk[1];
        k[2] = pk[3];
        k[3] = ppt_pkg::ONE_K + pk[4];
        k[4] = pk[6];
        k[5] = pk[7];
        c0_c = $signed(mi.p[2]);
        c1_c = $signed(mi.p[5]);
      end
      default: begin
        k[0] = ppt_pkg::ONE_K;
        k[3] = ppt_pkg::ONE_K;
      end
    endcase
    for (int j = 0; j < 6; j++) begin
      if (j % 2 == 0) begin
        m1_lo_nxt[j] = $signed({1'b0, k[j][ppt_pkg::SPLIT-1:0]}) * mi.x;
        m1_hi_nxt[j] = $signed(k[j][ppt_pkg::KW-1:ppt_pkg::SPLIT]) * mi.x;
      end else begin
        m1_lo_nxt[j] = $signed({1'b0, k[j][ppt_pkg::SPLIT-1:0]}) * mi.y;
        m1_hi_nxt[j] = $signed(k[j][ppt_pkg::KW-1:ppt_pkg::SPLIT]) * mi.y;
      end
    end
  end

  // Combine partial products, then sum at scale 2^48
  always_comb begin
    for (int j = 0; j < 6; j++) begin
      m2_prod_nxt[j] = (ppt_pkg::PRW'(m1_hi_r[j]) <<< ppt_pkg::SPLIT)
                     + ppt_pkg::PRW'(m1_lo_r[j]);
    end
    m3_acc_nxt[0] = ppt_pkg::ACCW'(m2_prod_r[0]) + ppt_pkg::ACCW'(m2_prod_r[1])
                  + (ppt_pkg::ACCW'(m2_c0_r) <<< 16);
    m3_acc_nxt[1] = ppt_pkg::ACCW'(m2_prod_r[2]) + ppt_pkg::ACCW'(m2_prod_r[3])
                  + (ppt_pkg::ACCW'(m2_c1_r) <<< 16);
    m3_acc_nxt[2] = ppt_pkg::ACCW'(m2_prod_r[4]) + ppt_pkg::ACCW'(m2_prod_r[5])
                  + ppt_pkg::D_ONE;
  end

  // Round the linear result, and set up the homography divide
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      lin_rnd[j] = (m3_acc_r[j] + ppt_pkg::RND_HALF) >>> 32;
      if ((&lin_rnd[j][ppt_pkg::ACCW-1:31]) || !(|lin_rnd[j][ppt_pkg::ACCW-1:31])) begin
        lin_val[j] = lin_rnd[j][31:0];
        lin_sat[j] = 1'b0;
      end else begin
        lin_val[j] = lin_rnd[j][ppt_pkg::ACCW-1] ? ppt_pkg::SAT_NEG : ppt_pkg::SAT_POS;
        lin_sat[j] = 1'b1;
      end
      an[j]    = m3_acc_r[j][ppt_pkg::ACCW-1] ? ppt_pkg::ACCW'(-m3_acc_r[j])
                                               : ppt_pkg::ACCW'(m3_acc_r[j]);
    end
    ad = m3_acc_r[2][ppt_pkg::ACCW-1] ? ppt_pkg::ACCW'(-m3_acc_r[2])
                                      : ppt_pkg::ACCW'(m3_acc_r[2]);
    for (int j = 0; j < 2; j++) begin
      num_c[j] = (ppt_pkg::NW'(an[j]) << ppt_pkg::DIV_PRESHIFT) + ppt_pkg::NW'(ad);
    end
    side_c.homo    = m3_homo_r;
    side_c.lin_x   = lin_val[0];
    side_c.lin_y   = lin_val[1];
    side_c.lin_sat = |lin_sat;
    side_c.dzero   = (m3_acc_r[2] == '0);
    side_c.nneg    = {m3_acc_r[1][ppt_pkg::ACCW-1], m3_acc_r[0][ppt_pkg::ACCW-1]};
    side_c.qneg    = {m3_acc_r[1][ppt_pkg::ACCW-1] ^ m3_acc_r[2][ppt_pkg::ACCW-1],
                      m3_acc_r[0][ppt_pkg::ACCW-1] ^ m3_acc_r[2][ppt_pkg::ACCW-1]};
  end

  ppt_div u_div_x (
    .clk   (clk),
    .en    (adv),
    .num_i (h1_num_r[0]),
    .den_i (h1_den_r),
    .quo_o (quo[0]),
    .ovf_o (ovf[0])
  );

  ppt_div u_div_y (
    .clk   (clk),
    .en    (adv),
    .num_i (h1_num_r[1]),
    .den_i (h1_den_r),
    .quo_o (quo[1]),
    .ovf_o (ovf[1])
  );

  // Saturate the quotients and pick the result for the mode
  always_comb begin
    sd = sd_r[ND-1];
    for (int j = 0; j < 2; j++) begin
      if (ovf[j]) begin
        hq_val[j] = sd.qneg[j] ? ppt_pkg::SAT_NEG : ppt_pkg::SAT_POS;
        hq_sat[j] = 1'b1;
      end else if (sd.qneg[j]) begin
        if (quo[j] > ppt_pkg::QW'(ppt_pkg::SAT_NEG)) begin
          hq_val[j] = ppt_pkg::SAT_NEG;
          hq_sat[j] = 1'b1;
        end else begin
          hq_val[j] = ppt_pkg::XW'(-quo[j]);
          hq_sat[j] = 1'b0;
        end
      end else if (quo[j][ppt_pkg::QW-1] || quo[j][ppt_pkg::QW-2]) begin
        hq_val[j] = ppt_pkg::SAT_POS;
        hq_sat[j] = 1'b1;
      end else begin
        hq_val[j] = quo[j][ppt_pkg::XW-1:0];
        hq_sat[j] = 1'b0;
      end
    end
    if (!sd.homo) begin
      out_x_nxt      = sd.lin_x;
      out_y_nxt      = sd.lin_y;
      out_status_nxt = sd.lin_sat ? ppt_pkg::ST_SAT : ppt_pkg::ST_OK;
    end else if (sd.dzero) begin
      out_x_nxt      = sd.nneg[0] ? ppt_pkg::SAT_NEG : ppt_pkg::SAT_POS;
      out_y_nxt      = sd.nneg[1] ? ppt_pkg::SAT_NEG : ppt_pkg::SAT_POS;
      out_status_nxt = ppt_pkg::ST_DZERO;
    end else begin
      out_x_nxt      = hq_val[0];
      out_y_nxt      = hq_val[1];
      out_status_nxt = (|hq_sat) ? ppt_pkg::ST_SAT : ppt_pkg::ST_OK;
    end
  end

  // Pipeline registers: valid bits reset, data advances with adv
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_v_r      <= 1'b0;
      t2_v_r      <= 1'b0;
      cv_r        <= '0;
      m1_v_r      <= 1'b0;
      m2_v_r      <= 1'b0;
      m3_v_r      <= 1'b0;
      h1_v_r      <= 1'b0;
      sv_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      t1_v_r      <= in_valid;
      t2_v_r      <= t1_v_r;
      cv_r        <= cv_in;
      m1_v_r      <= cv_r[NC-1];
      m2_v_r      <= m1_v_r;
      m3_v_r      <= m2_v_r;
      h1_v_r      <= m3_v_r;
      sv_r        <= {sv_r[ND-2:0], h1_v_r};
      out_valid_r <= sv_r[ND-1];
    end
    if (adv) begin
      t1_item_r <= in_item;
      t1_plo_r  <= plo_c;
      t1_phi_r  <= phi_c;
      t2_item_r <= t1_item_r;
      t2_z_r    <= ppt_pkg::ZW'($signed(turn_f));
      t2_flip_r <= flip_c;
      cx_r      <= cx_nxt;
      cy_r      <= cy_nxt;
      cz_r      <= cz_nxt;
      cflip_r   <= cflip_in;
      citem_r   <= citem_in;
      m1_lo_r   <= m1_lo_nxt;
      m1_hi_r   <= m1_hi_nxt;
      m1_homo_r <= (mi.mode == ppt_pkg::MODE_HOMO);
      m1_c0_r   <= c0_c;
      m1_c1_r   <= c1_c;
      m2_prod_r <= m2_prod_nxt;
      m2_homo_r <= m1_homo_r;
      m2_c0_r   <= m1_c0_r;
      m2_c1_r   <= m1_c1_r;
      m3_acc_r  <= m3_acc_nxt;
      m3_homo_r <= m2_homo_r;
      h1_num_r  <= num_c;
      h1_den_r  <= ppt_pkg::DW'(ad) << 1;
      h1_side_r <= side_c;
      sd_r[0]   <= h1_side_r;
      for (int i = 1; i < ND; i++) begin
        sd_r[i] <= sd_r[i-1];
      end
      out_x_r      <= out_x_nxt;
      out_y_r      <= out_y_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_x_out  = $signed(out_x_r);
  assign out_y_out  = $signed(out_y_r);
  assign out_status = out_status_r;

  // Reset empties the pipeline tail by the next edge
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !h1_v_r && !m3_v_r)
    else $error("pipeline not empty after reset");

  // The input side is held back only by a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r && out_stall)
    else $error("input stalled without a waiting result");

  // A zero denominator always yields saturated coordinates
  a_dzero_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ppt_pkg::ST_DZERO |->
      (out_x_r == ppt_pkg::SAT_POS || out_x_r == ppt_pkg::SAT_NEG) &&
      (out_y_r == ppt_pkg::SAT_POS || out_y_r == ppt_pkg::SAT_NEG))
    else $error("zero denominator without saturated result");

endmodule
